/* sv/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// shared types for the double-ended queue: request codes, status codes,
// controller states and the controller-to-datapath command group
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_PEEK_FRONT = 3'd4,
        REQ_PEEK_BACK  = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // capture request fields
        logic exec;   // perform the ring operation
    } t_cmd;

endpackage

`default_nettype wire

/* sv/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque of signed 32-bit words held in a ring store with a front
// index and an occupancy count; push, pop and peek at either end
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  request   in         start & !busy          i_req_type, i_push_value
//  result    out        o_strobe (one cycle)   o_read_value, o_status, o_occupancy
//
//  - each request passes through load, execute and respond: the transfer
//    loads the request register, execute updates the indices and the
//    registered read port of the ring store, and respond raises the strobe
//  - busy is high from the cycle after a transfer until the strobe cycle
//    ends; a new request can transfer the cycle after the strobe
//  - synchronous active-low reset empties the deque (front index and count
//    go to zero); the store itself is not cleared
//  - the receiver cannot stall: a result is valid only while o_strobe is high
//
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    i_req_type,
    input  wire logic signed [31:0]            i_push_value,
    output logic                               o_strobe,
    output logic signed [31:0]                 o_read_value,
    output logic [1:0]                         o_status,
    output logic [$clog2(DEPTH+1)-1:0]         o_occupancy
);

    // command group from sequencer to datapath
    dq_pkg::t_cmd cmd;

    // sequencer: accepts a transfer in idle, then execute, then strobe
    dq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd)
    );

    // ring store and indices; outputs stay stable through the strobe cycle
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_type   (i_req_type),
        .i_push_value (i_push_value),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

endmodule

`default_nettype wire

/* sv/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl
// request sequencer: idle, execute, respond
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    output logic              o_strobe,
    output dq_pkg::t_cmd      o_cmd
);

    dq_pkg::t_state r_state;
    dq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dq_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = dq_pkg::ST_EXEC;
                end
            end
            dq_pkg::ST_EXEC: begin
                n_state = dq_pkg::ST_RESP;
            end
            dq_pkg::ST_RESP: begin
                n_state = dq_pkg::ST_IDLE;
            end
            default: begin
                n_state = dq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy       = 1'b1;
        o_strobe   = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        case (r_state)
            dq_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            dq_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            dq_pkg::ST_RESP: begin
                o_strobe = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // a result strobe always follows an execute cycle
    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(o_cmd.exec))
        else $error("strobe without execute");

    // a transfer in starts execution on the next cycle
    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("load not followed by execute");

    // no load while busy
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !busy)
        else $error("load while busy");

endmodule

`default_nettype wire

/* sv/dq_datapath.sv */
// ----------------------------------------------------------------------------
// dq_datapath
// ring store, front index and occupancy count with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module dq_datapath #(
    parameter int DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dq_pkg::t_cmd                  i_cmd,
    input  wire logic [2:0]                    i_req_type,
    input  wire logic signed [31:0]            i_push_value,
    output logic signed [31:0]                 o_read_value,
    output logic [1:0]                         o_status,
    output logic [$clog2(DEPTH+1)-1:0]         o_occupancy
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]        r_mem [DEPTH];
    logic [2:0]         r_req;
    logic [31:0]        r_value;
    logic [IW-1:0]      r_front;
    logic [CW-1:0]      r_count;
    logic [31:0]        r_rd_data;
    logic               r_rd_en;
    dq_pkg::t_status    r_status;

    logic [IW-1:0]      n_front;
    logic [CW-1:0]      n_count;
    dq_pkg::t_status    n_status;
    logic               wr_en;
    logic               rd_en;
    logic [IW-1:0]      wr_addr;
    logic [IW-1:0]      rd_addr;
    logic               is_full;
    logic               is_empty;
    logic [CW:0]        sum_tail;
    logic [CW:0]        sum_back;
    logic [IW-1:0]      tail_idx;
    logic [IW-1:0]      back_idx;
    logic [IW-1:0]      front_dec;
    logic [IW-1:0]      front_inc;

    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // ring positions with one compare-and-subtract wrap
    assign sum_tail = (CW+1)'(r_front) + (CW+1)'(r_count);
    assign sum_back = sum_tail - (CW+1)'(1);
    assign tail_idx = (sum_tail >= (CW+1)'(DEPTH)) ?
                      IW'(sum_tail - (CW+1)'(DEPTH)) : IW'(sum_tail);
    assign back_idx = (sum_back >= (CW+1)'(DEPTH)) ?
                      IW'(sum_back - (CW+1)'(DEPTH)) : IW'(sum_back);
    assign front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - IW'(1);
    assign front_inc = (r_front == IW'(DEPTH - 1)) ? '0 : r_front + IW'(1);

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = dq_pkg::STS_OK;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        wr_addr  = tail_idx;
        rd_addr  = r_front;
        case (dq_pkg::t_req'(r_req))
            dq_pkg::REQ_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = dq_pkg::STS_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = front_dec;
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                end
            end
            dq_pkg::REQ_PUSH_BACK: begin
                if (is_full) begin
                    n_status = dq_pkg::STS_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_PEEK_FRONT: begin
                if (is_empty) begin
                    n_status = dq_pkg::STS_EMPTY;
                end else begin
                    rd_en = 1'b1;
                    if (r_req == dq_pkg::REQ_POP_FRONT) begin
                        n_front = front_inc;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            dq_pkg::REQ_POP_BACK, dq_pkg::REQ_PEEK_BACK: begin
                if (is_empty) begin
                    n_status = dq_pkg::STS_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = back_idx;
                    if (r_req == dq_pkg::REQ_POP_BACK) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_status = dq_pkg::STS_OK;
            end
        endcase
    end

    // store: one write or one registered read per execute cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= r_value;
        end
        if (i_cmd.exec && rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_type;
            r_value <= i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_rd_en  <= 1'b0;
            r_status <= dq_pkg::STS_OK;
        end else if (i_cmd.exec) begin
            r_front  <= n_front;
            r_count  <= n_count;
            r_rd_en  <= rd_en;
            r_status <= n_status;
        end
    end

    assign o_read_value = r_rd_en ? $signed(r_rd_data) : 32'sd0;
    assign o_status     = r_status;
    assign o_occupancy  = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == dq_pkg::STS_FULL) |-> (r_count == CW'(DEPTH)))
        else $error("full status with room left");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == dq_pkg::STS_EMPTY) |-> (r_count == '0) && !r_rd_en)
        else $error("empty status with data present");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && wr_en) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow occupancy");

endmodule

`default_nettype wire
